// ===== rtl/core/block_bitmap_first_fit_allocator_assert.svh =====
// Assertion macros shared by the allocator checker.
`ifndef BLOCK_BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBFF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbff: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbff: next-cycle check failed");

`endif

// ===== rtl/core/bbff_pkg.sv =====
// Shared widths, codes and defaults of the bitmap first-fit block allocator.
package bbff_pkg;

    localparam int MAX_GROUPS_DEF     = 16;
    localparam int BITS_PER_GROUP_DEF = 8192;

    localparam int CMD_W     = 2;
    localparam int GSEL_W    = 4;
    localparam int WIDX_W    = 8;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 14;
    localparam int STATUS_W  = 2;
    localparam int BLKNUM_W  = 18;
    localparam int BPG_W     = 14;
    localparam int GCNT_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 14;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY     = 2'd0,
        CMD_ALLOC     = 2'd1,
        CMD_LOAD_WORD = 2'd2,
        CMD_SET_COUNT = 2'd3
    } cmd_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_NONE  = 2'd1,
        ST_LOAD  = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT      = 1'b1;

    localparam logic [BPG_W-1:0]  BPG_RESET  = 14'd8192;
    localparam logic [GCNT_W-1:0] GCNT_RESET = 5'd1;

endpackage

// ===== rtl/core/bbff_if.sv =====
// Valid/ready channel interfaces of the allocator: request, response and configuration.
interface bbff_req_if;
    logic                          valid;
    logic                          ready;
    logic [bbff_pkg::CMD_W-1:0]    cmd;
    logic [bbff_pkg::GSEL_W-1:0]   group_sel;
    logic [bbff_pkg::WIDX_W-1:0]   word_index;
    logic [bbff_pkg::WORD_W-1:0]   word_value;
    logic [bbff_pkg::COUNT_W-1:0]  count_value;

    modport source (output valid, cmd, group_sel, word_index, word_value, count_value,
                    input ready);
    modport sink   (input valid, cmd, group_sel, word_index, word_value, count_value,
                    output ready);
endinterface

interface bbff_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bbff_pkg::STATUS_W-1:0] status;
    logic [bbff_pkg::BLKNUM_W-1:0] block_number;

    modport source (output valid, status, block_number, input ready);
    modport sink   (input valid, status, block_number, output ready);
endinterface

interface bbff_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bbff_pkg::CFG_IDX_W-1:0] index;
    logic [bbff_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/block_bitmap_first_fit_allocator.sv =====
// Top level of the bitmap first-fit block allocator.
//
// Channels: req carries one command beat (query, allocate, load bitmap word,
// set group free count); rsp returns exactly one beat per request with a
// status and a one-based block number; cfg writes blocks_per_group (index 0)
// and group_count (index 1) and is always ready.
// Loads and count writes answer in the cycle after the request beat is taken.
// A query or allocate visits the groups in order, skips a group whose free
// count is zero, and reads the bitmap words of a group with free blocks one
// by one until a clear bit is found; it answers with status none once every
// group is visited. With a total free count of zero it answers as a load does.
// One word of the single bitmap memory read port is tested per cycle, so a
// full group of BITS_PER_GROUP/32 words (256 by default) sets the scan time.
// Only one request is in flight; req.ready is low while a scan runs.
// After reset the bitmap memory is swept to zero, one word per cycle, over
// all MAX_GROUPS*BITS_PER_GROUP/32 words (4096 by default); requests wait for
// it, configuration writes are taken during the sweep.
// The response sits in an output register; while rsp.ready is low the beat
// holds and no new request is taken, but a new request is taken in the same
// cycle the waiting beat leaves.
module block_bitmap_first_fit_allocator #(
    parameter int MAX_GROUPS     = bbff_pkg::MAX_GROUPS_DEF,
    parameter int BITS_PER_GROUP = bbff_pkg::BITS_PER_GROUP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bbff_cfg_if.sink    cfg,
    bbff_req_if.sink    req,
    bbff_rsp_if.source  rsp
);

    localparam int WPG      = BITS_PER_GROUP / 32;
    localparam int WPG_SCAN = (BITS_PER_GROUP + 31) / 32;
    localparam int DEPTH    = MAX_GROUPS * WPG;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW      = $clog2(MAX_GROUPS + 1);
    localparam int BW       = $clog2(BITS_PER_GROUP + 1);
    localparam int WW       = (WPG_SCAN > 1) ? $clog2(WPG_SCAN) : 1;
    localparam int NW       = bbff_pkg::BLKNUM_W;
    localparam int DW       = bbff_pkg::WORD_W;
    localparam int CW       = bbff_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_GROUP = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic [bbff_pkg::BPG_W-1:0]  bpg_reg;
    logic [bbff_pkg::GCNT_W-1:0] gcnt_reg;
    logic [NW-1:0]               total_reg, total_next;
    logic [CW-1:0]               cnt_reg [MAX_GROUPS];
    logic                        out_valid_reg, out_valid_next;
    logic [bbff_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NW-1:0]               out_num_reg, out_num_next;

    // Scan datapath registers.
    logic                        take_reg, take_next;
    logic [GCW-1:0]              groups_reg, groups_next;
    logic [BW-1:0]               bits_reg, bits_next;
    logic [WW-1:0]               last_word_reg, last_word_next;
    logic [DW-1:0]               tail_mask_reg, tail_mask_next;
    logic [GCW-1:0]              g_reg, g_next;
    logic [AW-1:0]               base_addr_reg, base_addr_next;
    logic [NW-1:0]               base_num_reg, base_num_next;
    logic [WW-1:0]               w_reg, w_next;

    // Bitmap memory.
    logic [DW-1:0]               mem [DEPTH];
    logic [DW-1:0]               rdata_reg;
    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [DW-1:0]               mem_wdata;

    logic                        cnt_we;
    logic [GW-1:0]               cnt_idx;
    logic [CW-1:0]               cnt_rd, cnt_wval;

    logic                        req_fire;
    logic [BW-1:0]               bits_cfg;
    logic [GCW-1:0]              groups_cfg;
    logic [DW-1:0]               free_bits;
    logic                        free_any;
    logic [4:0]                  ffs;
    logic [NW-1:0]               hit_num;
    logic                        load_ok, group_ok;
    logic [AW-1:0]               load_addr;

    // Handshake outputs.
    assign cfg.ready        = 1'b1;
    assign req.ready        = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.block_number = out_num_reg;
    assign req_fire         = req.valid && req.ready;

    // One read port on the group free counts: scan group or addressed group.
    assign cnt_idx = ((state_reg == S_GROUP) || (state_reg == S_SCAN))
                     ? g_reg[GW-1:0] : GW'(req.group_sel);
    assign cnt_rd  = cnt_reg[cnt_idx];

    // Effective scan limits from the configuration registers.
    assign bits_cfg   = (32'(bpg_reg) < BITS_PER_GROUP) ? BW'(bpg_reg) : BW'(BITS_PER_GROUP);
    assign groups_cfg = (32'(gcnt_reg) < MAX_GROUPS) ? GCW'(gcnt_reg) : GCW'(MAX_GROUPS);

    // Load decode.
    assign group_ok  = 32'(req.group_sel) < MAX_GROUPS;
    assign load_ok   = group_ok && (32'(req.word_index) < WPG);
    assign load_addr = AW'(32'(req.group_sel) * WPG + 32'(req.word_index));

    // Free bits of the word under test; the last word of a group is trimmed.
    assign free_bits = ~rdata_reg & ((w_reg == last_word_reg) ? tail_mask_reg : '1);
    assign free_any  = |free_bits;

    // Lowest clear bit of the word under test.
    always_comb
    begin
        ffs = '0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                ffs = 5'(i);
            end
        end
    end

    assign hit_num = base_num_reg + NW'({w_reg, 5'b0}) + NW'(ffs) + NW'(1);

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_num_next    = out_num_reg;
        take_next       = take_reg;
        groups_next     = groups_reg;
        bits_next       = bits_reg;
        last_word_next  = last_word_reg;
        tail_mask_next  = tail_mask_reg;
        g_next          = g_reg;
        base_addr_next  = base_addr_reg;
        base_num_next   = base_num_reg;
        w_next          = w_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = base_addr_reg;
        cnt_we          = 1'b0;
        cnt_wval        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bbff_pkg::ST_LOAD;
                    out_num_next    = '0;
                    unique case (req.cmd) inside
                        bbff_pkg::CMD_QUERY, bbff_pkg::CMD_ALLOC:
                        begin
                            take_next      = (req.cmd == bbff_pkg::CMD_ALLOC);
                            groups_next    = groups_cfg;
                            bits_next      = bits_cfg;
                            last_word_next = WW'((32'(bits_cfg) + 31) >> 5) - WW'(1);
                            tail_mask_next = (bits_cfg[4:0] == 5'd0) ? '1
                                             : (DW'(1) << bits_cfg[4:0]) - DW'(1);
                            g_next         = '0;
                            base_addr_next = '0;
                            base_num_next  = '0;
                            if (total_reg == '0)
                            begin
                                out_status_next = bbff_pkg::ST_NONE;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                state_next     = S_GROUP;
                            end
                        end
                        bbff_pkg::CMD_LOAD_WORD:
                        begin
                            mem_we    = load_ok;
                            mem_waddr = load_addr;
                            mem_wdata = req.word_value;
                        end
                        default:
                        begin
                            if (group_ok)
                            begin
                                cnt_we     = 1'b1;
                                cnt_wval   = req.count_value;
                                total_next = total_reg + NW'(req.count_value) - NW'(cnt_rd);
                            end
                        end
                    endcase
                end
            end

            S_GROUP:
            begin
                if (g_reg == groups_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bbff_pkg::ST_NONE;
                    out_num_next    = '0;
                    state_next      = S_IDLE;
                end
                else if ((cnt_rd == '0) || (bits_reg == '0))
                begin
                    g_next         = g_reg + GCW'(1);
                    base_addr_next = base_addr_reg + AW'(WPG);
                    base_num_next  = base_num_reg + NW'(bits_reg);
                end
                else
                begin
                    w_next     = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = base_addr_reg;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (free_any)
                begin
                    if (take_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = base_addr_reg + AW'(w_reg);
                        mem_wdata  = rdata_reg | (DW'(1) << ffs);
                        cnt_we     = 1'b1;
                        cnt_wval   = cnt_rd - CW'(1);
                        total_next = total_reg - NW'(1);
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = bbff_pkg::ST_FOUND;
                    out_num_next    = hit_num;
                    state_next      = S_IDLE;
                end
                else if (w_reg == last_word_reg)
                begin
                    g_next         = g_reg + GCW'(1);
                    base_addr_next = base_addr_reg + AW'(WPG);
                    base_num_next  = base_num_reg + NW'(bits_reg);
                    state_next     = S_GROUP;
                end
                else
                begin
                    w_next    = w_reg + WW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = base_addr_reg + AW'(w_reg) + AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration registers and free counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            bpg_reg       <= bbff_pkg::BPG_RESET;
            gcnt_reg      <= bbff_pkg::GCNT_RESET;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_idx] <= cnt_wval;
            end
            if (cfg.valid)
            begin
                if (cfg.index == bbff_pkg::REG_BLOCKS_PER_GROUP)
                begin
                    bpg_reg <= cfg.data;
                end
                else
                begin
                    gcnt_reg <= cfg.data[bbff_pkg::GCNT_W-1:0];
                end
            end
        end
    end

    // Payload and scan datapath registers.
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_num_reg    <= out_num_next;
        take_reg       <= take_next;
        groups_reg     <= groups_next;
        bits_reg       <= bits_next;
        last_word_reg  <= last_word_next;
        tail_mask_reg  <= tail_mask_next;
        g_reg          <= g_next;
        base_addr_reg  <= base_addr_next;
        base_num_reg   <= base_num_next;
        w_reg          <= w_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== rtl/core/bbff_checker.sv =====
// Port-level checker of the allocator and its bind to the top level.
`include "block_bitmap_first_fit_allocator_assert.svh"

module bbff_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [bbff_pkg::CMD_W-1:0]    req_cmd,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bbff_pkg::STATUS_W-1:0] rsp_status,
    input logic [bbff_pkg::BLKNUM_W-1:0] rsp_block_number
);

    // A stalled response beat keeps its payload.
    `BBFF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_block_number))

    // While a response waits, no new request beat is taken.
    `BBFF_ASSERT_SAME(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)

    // Loads and count writes answer in the next cycle.
    `BBFF_ASSERT_NEXT(a_load_answers, req_valid && req_ready && req_cmd[1], rsp_valid && (rsp_status == bbff_pkg::ST_LOAD))

    // A found block is one-based and never zero.
    `BBFF_ASSERT_SAME(a_found_nonzero, rsp_valid && (rsp_status == bbff_pkg::ST_FOUND), rsp_block_number != '0)

endmodule

bind block_bitmap_first_fit_allocator bbff_checker u_bbff_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_cmd          (req.cmd),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_block_number (rsp.block_number)
);
